// ===== rtl/dcd_pkg.sv =====
// Shared types and constants for the dangerous command detector.
// Holds the pattern text table, category codes and the normalizer state encodings.
// No dependencies.
package dcd_pkg;

    localparam int WIN_LEN   = 18;
    localparam int NUM_PAT   = 15;
    localparam int PAT_BYTES = 19;
    localparam int MAX_PUSH  = 3;
    localparam int EXT_LEN   = WIN_LEN + MAX_PUSH;

    // Pattern text is right aligned: the final character sits in bits [7:0].
    localparam logic [PAT_BYTES*8-1:0] PAT_TEXT [NUM_PAT] = '{
        "rm -rf /",
        "rm -fr /",
        "rm -rf",
        " --no-preserve-root",
        "mkfs",
        "format c:",
        "dd if=/dev/zero",
        "| sh",
        "| bash",
        "chmod 777 /",
        "chown -r /",
        ":(){ :|:& };:",
        "shutdown",
        "now",
        "-h"
    };

    localparam logic [4:0] PAT_LEN [NUM_PAT] = '{
        5'd8, 5'd8, 5'd6, 5'd19, 5'd4, 5'd9, 5'd15, 5'd4, 5'd6,
        5'd11, 5'd10, 5'd13, 5'd8, 5'd3, 5'd2
    };

    // Positions of the patterns in the hit vector.
    localparam int PAT_RM_RF_ROOT   = 0;
    localparam int PAT_RM_FR_ROOT   = 1;
    localparam int PAT_RM_RF        = 2;
    localparam int PAT_NO_PRESERVE  = 3;
    localparam int PAT_MKFS         = 4;
    localparam int PAT_FORMAT_C     = 5;
    localparam int PAT_DD_ZERO      = 6;
    localparam int PAT_PIPE_SH      = 7;
    localparam int PAT_PIPE_BASH    = 8;
    localparam int PAT_CHMOD_777    = 9;
    localparam int PAT_CHOWN_R      = 10;
    localparam int PAT_FORK_BOMB    = 11;
    localparam int PAT_SHUTDOWN     = 12;
    localparam int PAT_NOW          = 13;
    localparam int PAT_DASH_H       = 14;

    typedef enum logic [2:0] {
        CAT_NONE       = 3'd0,
        CAT_RECURSIVE  = 3'd1,
        CAT_DISK_WIPE  = 3'd2,
        CAT_PIPE_SHELL = 3'd3,
        CAT_PERMISSION = 3'd4,
        CAT_FORK_BOMB  = 3'd5,
        CAT_SHUTDOWN   = 3'd6
    } t_category;

    typedef enum logic [1:0] {
        ESC_NORMAL = 2'd0,
        ESC_SEEN   = 2'd1,
        ESC_CSI    = 2'd2
    } t_esc_mode;

    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_EF   = 2'd1,
        HOLD_EFBC = 2'd2,
        HOLD_EFBD = 2'd3
    } t_utf8_hold;

    // Normalized bytes produced by one item, oldest in bytes[0].
    typedef struct packed {
        logic [1:0]            cnt;
        logic [2:0][7:0]       bytes;
    } t_push;

endpackage

// ===== rtl/dangerous_command_detector.sv =====
// A last item passes from the input stage register into the result register,
// from which its result is offered on the master side.
// Throughput: one item per cycle; all normalization and pattern compares for an
// item happen in a single pass between the input stage register and the state.
// Only a last item waits in the input stage, while an earlier result is not yet taken.
// Reset (i_rst_n low at a clock edge, synchronous) empties both stages and clears state.
module dangerous_command_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
    input  logic       s_axis_tuser,   // [0] has_byte
    input  logic       s_axis_tlast,   // last item of the command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] dangerous, [3:1] category, [7:4] zero
);

    // Input stage: the accepted item waits here until it advances.
    logic        r_stg_valid;
    logic [7:0]  r_stg_byte;
    logic        r_stg_has;
    logic        r_stg_last;

    // Per-command detection state: the window, the hit flags, the escape mode and
    // the held UTF-8 prefix.
    logic [7:0]                   r_win [dcd_pkg::WIN_LEN];
    logic [dcd_pkg::NUM_PAT-1:0]  r_hits;
    dcd_pkg::t_esc_mode           r_esc;
    dcd_pkg::t_utf8_hold          r_hold;

    // Result register.
    logic                r_out_valid;
    logic                r_out_dangerous;
    dcd_pkg::t_category  r_out_category;

    logic                         w_advance;
    dcd_pkg::t_push               w_push;
    dcd_pkg::t_esc_mode           n_esc;
    dcd_pkg::t_utf8_hold          n_hold;
    logic [dcd_pkg::NUM_PAT-1:0]  w_new_hits;
    logic [dcd_pkg::NUM_PAT-1:0]  w_all_hits;
    logic [7:0]                   n_win [dcd_pkg::WIN_LEN];
    dcd_pkg::t_category           w_category;

    // A non-last item always moves on; a last item needs the result register free
    // or being emptied in this same cycle.
    assign w_advance     = r_stg_valid && (!r_stg_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_stg_valid || w_advance;

    dcd_norm u_norm (
        .i_byte (r_stg_byte),
        .i_has  (r_stg_has),
        .i_last (r_stg_last),
        .i_esc  (r_esc),
        .i_hold (r_hold),
        .o_push (w_push),
        .o_esc  (n_esc),
        .o_hold (n_hold)
    );

    dcd_match u_match (
        .i_win  (r_win),
        .i_push (w_push),
        .o_hits (w_new_hits),
        .o_win  (n_win)
    );

    assign w_all_hits = r_hits | w_new_hits;

    // Categories in priority order; the first that applies is reported.
    always_comb begin
        if (w_all_hits[dcd_pkg::PAT_RM_RF_ROOT] || w_all_hits[dcd_pkg::PAT_RM_FR_ROOT] ||
            (w_all_hits[dcd_pkg::PAT_RM_RF] && w_all_hits[dcd_pkg::PAT_NO_PRESERVE])) begin
            w_category = dcd_pkg::CAT_RECURSIVE;
        end else if (w_all_hits[dcd_pkg::PAT_MKFS] || w_all_hits[dcd_pkg::PAT_FORMAT_C] ||
                     w_all_hits[dcd_pkg::PAT_DD_ZERO]) begin
            w_category = dcd_pkg::CAT_DISK_WIPE;
        end else if (w_all_hits[dcd_pkg::PAT_PIPE_SH] || w_all_hits[dcd_pkg::PAT_PIPE_BASH]) begin
            w_category = dcd_pkg::CAT_PIPE_SHELL;
        end else if (w_all_hits[dcd_pkg::PAT_CHMOD_777] || w_all_hits[dcd_pkg::PAT_CHOWN_R]) begin
            w_category = dcd_pkg::CAT_PERMISSION;
        end else if (w_all_hits[dcd_pkg::PAT_FORK_BOMB]) begin
            w_category = dcd_pkg::CAT_FORK_BOMB;
        end else if (w_all_hits[dcd_pkg::PAT_SHUTDOWN] &&
                     (w_all_hits[dcd_pkg::PAT_NOW] || w_all_hits[dcd_pkg::PAT_DASH_H])) begin
            w_category = dcd_pkg::CAT_SHUTDOWN;
        end else begin
            w_category = dcd_pkg::CAT_NONE;
        end
    end

    // Input stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_stg_valid <= 1'b1;
        end else if (w_advance) begin
            r_stg_valid <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_stg_byte <= s_axis_tdata;
            r_stg_has  <= s_axis_tuser;
            r_stg_last <= s_axis_tlast;
        end
    end

    // Detection state: updated per item, cleared after the last item of a command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dcd_pkg::WIN_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_hits <= '0;
            r_esc  <= dcd_pkg::ESC_NORMAL;
            r_hold <= dcd_pkg::HOLD_NONE;
        end else if (w_advance) begin
            if (r_stg_last) begin
                for (int i = 0; i < dcd_pkg::WIN_LEN; i++) begin
                    r_win[i] <= '0;
                end
                r_hits <= '0;
                r_esc  <= dcd_pkg::ESC_NORMAL;
                r_hold <= dcd_pkg::HOLD_NONE;
            end else begin
                r_win  <= n_win;
                r_hits <= w_all_hits;
                r_esc  <= n_esc;
                r_hold <= n_hold;
            end
        end
    end

    // Result register: loaded when a last item completes, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_stg_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && r_stg_last) begin
            r_out_dangerous <= (w_category != dcd_pkg::CAT_NONE);
            r_out_category  <= w_category;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_category, r_out_dangerous};

endmodule

// ===== rtl/dcd_norm.sv =====
// Byte normalizer of the dangerous command detector.
// Strips NUL, ESC and CSI sequences, folds fullwidth UTF-8 and lowercases.
// Depends on dcd_pkg.
module dcd_norm (
    input  logic [7:0]          i_byte,
    input  logic                i_has,
    input  logic                i_last,
    input  dcd_pkg::t_esc_mode  i_esc,
    input  dcd_pkg::t_utf8_hold i_hold,
    output dcd_pkg::t_push      o_push,
    output dcd_pkg::t_esc_mode  o_esc,
    output dcd_pkg::t_utf8_hold o_hold
);

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_EF   = 8'hEF;
    localparam logic [7:0] CH_BC   = 8'hBC;
    localparam logic [7:0] CH_BD   = 8'hBD;

    logic [7:0]          v_b [3];
    logic [1:0]          v_n;
    logic                v_go;
    dcd_pkg::t_esc_mode  v_esc;
    dcd_pkg::t_utf8_hold v_hold;
    logic                w_upper;
    logic                w_letter;

    assign w_upper  = (i_byte >= 8'h41) && (i_byte <= 8'h5A);
    assign w_letter = w_upper || ((i_byte >= 8'h61) && (i_byte <= 8'h7A));

    always_comb begin
        v_b[0] = '0;
        v_b[1] = '0;
        v_b[2] = '0;
        v_n    = '0;
        v_go   = 1'b0;
        v_esc  = i_esc;
        v_hold = i_hold;

        if (i_has && (i_byte != CH_NUL)) begin
            if (v_esc == dcd_pkg::ESC_CSI) begin
                if (w_letter) begin
                    v_esc = dcd_pkg::ESC_NORMAL;
                end
            end else begin
                v_go = 1'b1;
                if (v_esc == dcd_pkg::ESC_SEEN) begin
                    v_esc = dcd_pkg::ESC_NORMAL;
                    if (i_byte == CH_LBR) begin
                        v_esc = dcd_pkg::ESC_CSI;
                        v_go  = 1'b0;
                    end
                end
            end

            if (v_go) begin
                case (v_hold)
                    dcd_pkg::HOLD_EF: begin
                        if (i_byte == CH_BC) begin
                            v_hold = dcd_pkg::HOLD_EFBC;
                            v_go   = 1'b0;
                        end else if (i_byte == CH_BD) begin
                            v_hold = dcd_pkg::HOLD_EFBD;
                            v_go   = 1'b0;
                        end else begin
                            v_b[v_n] = CH_EF;
                            v_n      = v_n + 2'd1;
                            v_hold   = dcd_pkg::HOLD_NONE;
                        end
                    end
                    dcd_pkg::HOLD_EFBC: begin
                        v_hold = dcd_pkg::HOLD_NONE;
                        if (i_byte inside {[8'h81:8'hBF]}) begin
                            // The mapped range includes uppercase letters.
                            v_b[v_n] = i_byte - 8'h60;
                            if ((v_b[v_n] >= 8'h41) && (v_b[v_n] <= 8'h5A)) begin
                                v_b[v_n] = v_b[v_n] + 8'h20;
                            end
                            v_n      = v_n + 2'd1;
                            v_go     = 1'b0;
                        end else begin
                            v_b[v_n] = CH_EF;
                            v_n      = v_n + 2'd1;
                            v_b[v_n] = CH_BC;
                            v_n      = v_n + 2'd1;
                        end
                    end
                    dcd_pkg::HOLD_EFBD: begin
                        v_hold = dcd_pkg::HOLD_NONE;
                        if (i_byte inside {[8'h80:8'h9E]}) begin
                            v_b[v_n] = i_byte - 8'h20;
                            v_n  = v_n + 2'd1;
                            v_go = 1'b0;
                        end else begin
                            v_b[v_n] = CH_EF;
                            v_n      = v_n + 2'd1;
                            v_b[v_n] = CH_BD;
                            v_n      = v_n + 2'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (v_go) begin
                if (i_byte == CH_ESC) begin
                    v_esc = dcd_pkg::ESC_SEEN;
                end else if (i_byte == CH_EF) begin
                    v_hold = dcd_pkg::HOLD_EF;
                end else begin
                    v_b[v_n] = w_upper ? (i_byte + 8'h20) : i_byte;
                    v_n      = v_n + 2'd1;
                end
            end
        end

        // End of command: held prefix bytes go out unchanged, an open escape is dropped.
        if (i_last) begin
            if (v_hold != dcd_pkg::HOLD_NONE) begin
                v_b[v_n] = CH_EF;
                v_n      = v_n + 2'd1;
            end
            if (v_hold == dcd_pkg::HOLD_EFBC) begin
                v_b[v_n] = CH_BC;
                v_n      = v_n + 2'd1;
            end
            if (v_hold == dcd_pkg::HOLD_EFBD) begin
                v_b[v_n] = CH_BD;
                v_n      = v_n + 2'd1;
            end
            v_hold = dcd_pkg::HOLD_NONE;
            v_esc  = dcd_pkg::ESC_NORMAL;
        end
    end

    assign o_push.cnt      = v_n;
    assign o_push.bytes[0] = v_b[0];
    assign o_push.bytes[1] = v_b[1];
    assign o_push.bytes[2] = v_b[2];
    assign o_esc           = v_esc;
    assign o_hold          = v_hold;

endmodule

// ===== rtl/dcd_match.sv =====
// Window matcher of the dangerous command detector.
// Compares every pattern against the window after each pushed byte and shifts the window.
// Depends on dcd_pkg.
module dcd_match (
    input  logic [7:0]                   i_win [dcd_pkg::WIN_LEN],
    input  dcd_pkg::t_push               i_push,
    output logic [dcd_pkg::NUM_PAT-1:0]  o_hits,
    output logic [7:0]                   o_win [dcd_pkg::WIN_LEN]
);

    logic [7:0] w_ext [dcd_pkg::EXT_LEN];
    logic       v_match;

    always_comb begin
        for (int i = 0; i < dcd_pkg::WIN_LEN; i++) begin
            w_ext[i] = i_win[i];
        end
        for (int j = 0; j < dcd_pkg::MAX_PUSH; j++) begin
            w_ext[dcd_pkg::WIN_LEN + j] = i_push.bytes[j];
        end
    end

    // The window after push j ends at w_ext[WIN_LEN + j]; every pattern is
    // checked against each such ending in parallel.
    always_comb begin
        o_hits  = '0;
        v_match = 1'b0;
        for (int j = 0; j < dcd_pkg::MAX_PUSH; j++) begin
            for (int p = 0; p < dcd_pkg::NUM_PAT; p++) begin
                v_match = (2'(j) < i_push.cnt);
                for (int k = 0; k < dcd_pkg::PAT_BYTES; k++) begin
                    if ((5'(k) < dcd_pkg::PAT_LEN[p]) &&
                        (w_ext[dcd_pkg::WIN_LEN + j - k] != dcd_pkg::PAT_TEXT[p][k*8 +: 8])) begin
                        v_match = 1'b0;
                    end
                end
                o_hits[p] = o_hits[p] | v_match;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < dcd_pkg::WIN_LEN; i++) begin
            case (i_push.cnt)
                2'd1:    o_win[i] = w_ext[i + 1];
                2'd2:    o_win[i] = w_ext[i + 2];
                2'd3:    o_win[i] = w_ext[i + 3];
                default: o_win[i] = w_ext[i];
            endcase
        end
    end

endmodule

// ===== rtl/dcd_checker.sv =====
// Port-level checks for the dangerous command detector, bound to the top level.
// Depends on dcd_pkg and dangerous_command_detector.
module dcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tuser,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // The result stage is empty right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // The dangerous flag agrees with the category.
    a_flag_matches_category: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] != dcd_pkg::CAT_NONE)))
        else $error("dangerous flag disagrees with category");

    // A fresh result comes from an accepted last item.
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(m_axis_tvalid) && $past(i_rst_n)) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a last item");

    // A stalled result holds its value.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind dangerous_command_detector dcd_checker u_dcd_checker (.*);
